FILE: rtl/mflr_pkg.sv
// Shared types, constants and name tables for the mailbox separator line recogniser.
`timescale 1ns / 1ps

package mflr_pkg;

	typedef enum logic [4:0] {
		PH_PREFIX  = 5'd0,
		PH_SP_ADDR = 5'd1,
		PH_ADDR    = 5'd2,
		PH_SP_WDAY = 5'd3,
		PH_WDAY    = 5'd4,
		PH_SP_MON  = 5'd5,
		PH_MON     = 5'd6,
		PH_SP_DAY  = 5'd7,
		PH_DAYD    = 5'd8,
		PH_SP_TIME = 5'd9,
		PH_TIME    = 5'd10,
		PH_SP_TZ   = 5'd11,
		PH_TZ      = 5'd12,
		PH_SP_YEAR = 5'd13,
		PH_YEAR    = 5'd14,
		PH_SP_MZ   = 5'd15,
		PH_MZ      = 5'd16,
		PH_TAIL    = 5'd17
	} phase_t;

	typedef enum logic [2:0] {
		RSN_OK      = 3'd0,
		RSN_PREFIX  = 3'd1,
		RSN_WEEKDAY = 3'd2,
		RSN_MONTH   = 3'd3,
		RSN_DAY     = 3'd4,
		RSN_TIME    = 3'd5,
		RSN_YEAR    = 3'd6,
		RSN_EXTRA   = 3'd7
	} reason_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  pos;
		logic [11:0] cand;
		reason_t     fcode;
		logic        failed;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		phase:  PH_PREFIX,
		pos:    3'd0,
		cand:   12'hFFF,
		fcode:  RSN_OK,
		failed: 1'b0
	};

	localparam int NUM_WDAYS = 7;
	localparam int NUM_MONTHS = 12;
	localparam int PREFIX_LEN = 5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [7:0] PREFIX_TXT [PREFIX_LEN] = '{"F", "r", "o", "m", " "};

	localparam logic [7:0] WDAY_TXT [NUM_WDAYS*3] = '{
		"M","o","n", "T","u","e", "W","e","d", "T","h","u",
		"F","r","i", "S","a","t", "S","u","n"};

	localparam logic [7:0] MONTH_TXT [NUM_MONTHS*3] = '{
		"J","a","n", "F","e","b", "M","a","r", "A","p","r",
		"M","a","y", "J","u","n", "J","u","l", "A","u","g",
		"S","e","p", "O","c","t", "N","o","v", "D","e","c"};

	// Verdict that applies if the line were to finish in the given phase.
	function automatic reason_t end_verdict(phase_t ph);
		reason_t r;
		case (ph)
			PH_PREFIX: r = RSN_PREFIX;
			PH_SP_ADDR, PH_ADDR, PH_SP_WDAY, PH_WDAY: r = RSN_WEEKDAY;
			PH_SP_MON, PH_MON: r = RSN_MONTH;
			PH_SP_DAY: r = RSN_DAY;
			PH_DAYD, PH_SP_TIME, PH_TIME: r = RSN_TIME;
			PH_SP_TZ, PH_TZ, PH_SP_YEAR, PH_YEAR: r = RSN_YEAR;
			PH_SP_MZ, PH_TAIL: r = RSN_OK;
			default: r = RSN_EXTRA;
		endcase
		return r;
	endfunction

	function automatic logic [NUM_WDAYS-1:0] wday_hits(logic [1:0] pos, logic [7:0] c);
		logic [NUM_WDAYS-1:0] h;
		h = '0;
		if (pos != 2'd3) begin
			for (int i = 0; i < NUM_WDAYS; i++) begin
				h[i] = (WDAY_TXT[i*3 + int'(pos)] == c);
			end
		end
		return h;
	endfunction

	function automatic logic [NUM_MONTHS-1:0] month_hits(logic [1:0] pos, logic [7:0] c);
		logic [NUM_MONTHS-1:0] h;
		h = '0;
		if (pos != 2'd3) begin
			for (int i = 0; i < NUM_MONTHS; i++) begin
				h[i] = (MONTH_TXT[i*3 + int'(pos)] == c);
			end
		end
		return h;
	endfunction

endpackage

FILE: rtl/mflr_step.sv
// Next-state and verdict logic for one character of the separator line scanner.
`timescale 1ns / 1ps

module mflr_step (
	input  mflr_pkg::scan_state_t st,
	input  logic [7:0]            c,
	input  logic                  eol,
	output mflr_pkg::scan_state_t nxt,
	output mflr_pkg::reason_t     code
);

	mflr_pkg::phase_t ph_e;
	logic [2:0]  pos_e;
	logic [11:0] cand_e;
	logic [11:0] cand_n;
	logic        sp;
	logic        dig;
	logic        cap;
	logic        time_ok;

	function automatic mflr_pkg::scan_state_t enter(mflr_pkg::scan_state_t s,
			mflr_pkg::phase_t p);
		mflr_pkg::scan_state_t r;
		r = s;
		r.phase = p;
		r.pos = 3'd0;
		r.cand = 12'hFFF;
		return r;
	endfunction

	function automatic mflr_pkg::scan_state_t fail(mflr_pkg::scan_state_t s,
			mflr_pkg::reason_t why);
		mflr_pkg::scan_state_t r;
		r = s;
		r.failed = 1'b1;
		r.fcode = why;
		return r;
	endfunction

	assign sp  = (c == mflr_pkg::CH_SPACE);
	assign dig = (c >= 8'h30) && (c <= 8'h39);
	assign cap = (c >= 8'h41) && (c <= 8'h5A);

	always_comb begin
		// Gap phases hand a non-space character straight to the field that follows.
		ph_e = st.phase;
		pos_e = st.pos;
		cand_e = st.cand;
		case (st.phase)
			mflr_pkg::PH_SP_WDAY: if (!sp) begin
				ph_e = mflr_pkg::PH_WDAY; pos_e = 3'd0; cand_e = 12'hFFF;
			end
			mflr_pkg::PH_SP_MON: if (!sp) begin
				ph_e = mflr_pkg::PH_MON; pos_e = 3'd0; cand_e = 12'hFFF;
			end
			mflr_pkg::PH_DAYD, mflr_pkg::PH_SP_TIME: if (!sp && !(dig &&
					st.phase == mflr_pkg::PH_DAYD)) begin
				ph_e = mflr_pkg::PH_TIME; pos_e = 3'd0; cand_e = 12'hFFF;
			end
			mflr_pkg::PH_SP_TZ: if (!sp && !cap) begin
				ph_e = mflr_pkg::PH_YEAR; pos_e = 3'd0; cand_e = 12'hFFF;
			end
			mflr_pkg::PH_SP_YEAR: if (!sp) begin
				ph_e = mflr_pkg::PH_YEAR; pos_e = 3'd0; cand_e = 12'hFFF;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		nxt = st;
		code = st.failed ? st.fcode : mflr_pkg::end_verdict(st.phase);
		cand_n = 12'h000;
		time_ok = 1'b0;
		if (eol) begin
			nxt = mflr_pkg::SCAN_RESET;
		end else if (st.failed) begin
			nxt = st;
		end else if (c == mflr_pkg::CH_NUL) begin
			nxt = fail(st, mflr_pkg::end_verdict(st.phase));
		end else begin
			nxt.phase = ph_e;
			nxt.pos = pos_e;
			nxt.cand = cand_e;
			case (ph_e)
				mflr_pkg::PH_PREFIX: begin
					if (pos_e > 3'd4 || c != mflr_pkg::PREFIX_TXT[pos_e]) begin
						nxt = fail(nxt, mflr_pkg::RSN_PREFIX);
					end else if (pos_e == 3'd4) begin
						nxt = enter(nxt, mflr_pkg::PH_SP_ADDR);
					end else begin
						nxt.pos = pos_e + 3'd1;
					end
				end
				mflr_pkg::PH_SP_ADDR: if (!sp) begin
					nxt = enter(nxt, mflr_pkg::PH_ADDR);
				end
				mflr_pkg::PH_ADDR: if (sp) begin
					nxt = enter(nxt, mflr_pkg::PH_SP_WDAY);
				end
				mflr_pkg::PH_WDAY: begin
					cand_n = cand_e & {5'b0, mflr_pkg::wday_hits(pos_e[1:0], c)};
					if (pos_e > 3'd2 || cand_n == 12'h000) begin
						nxt = fail(nxt, mflr_pkg::RSN_WEEKDAY);
					end else if (pos_e == 3'd2) begin
						nxt = enter(nxt, mflr_pkg::PH_SP_MON);
					end else begin
						nxt.pos = pos_e + 3'd1;
						nxt.cand = cand_n;
					end
				end
				mflr_pkg::PH_MON: begin
					cand_n = cand_e & mflr_pkg::month_hits(pos_e[1:0], c);
					if (pos_e > 3'd2 || cand_n == 12'h000) begin
						nxt = fail(nxt, mflr_pkg::RSN_MONTH);
					end else if (pos_e == 3'd2) begin
						nxt = enter(nxt, mflr_pkg::PH_SP_DAY);
					end else begin
						nxt.pos = pos_e + 3'd1;
						nxt.cand = cand_n;
					end
				end
				mflr_pkg::PH_SP_DAY: begin
					if (!sp) begin
						if (!dig) begin
							nxt = fail(nxt, mflr_pkg::RSN_DAY);
						end else begin
							nxt = enter(nxt, mflr_pkg::PH_DAYD);
						end
					end
				end
				mflr_pkg::PH_DAYD: if (sp) begin
					nxt = enter(nxt, mflr_pkg::PH_SP_TIME);
				end
				mflr_pkg::PH_TIME: begin
					time_ok = (pos_e == 3'd2 || pos_e == 3'd5) ?
						(c == mflr_pkg::CH_COLON) : dig;
					if (!time_ok) begin
						nxt = fail(nxt, mflr_pkg::RSN_TIME);
					end else if (pos_e == 3'd7) begin
						nxt = enter(nxt, mflr_pkg::PH_SP_TZ);
					end else begin
						nxt.pos = pos_e + 3'd1;
					end
				end
				mflr_pkg::PH_SP_TZ: if (cap) begin
					nxt = enter(nxt, mflr_pkg::PH_TZ);
					nxt.pos = 3'd1;
				end
				mflr_pkg::PH_TZ: begin
					if (!cap) begin
						nxt = fail(nxt, mflr_pkg::RSN_YEAR);
					end else if (pos_e >= 3'd2) begin
						nxt = enter(nxt, mflr_pkg::PH_SP_YEAR);
					end else begin
						nxt.pos = pos_e + 3'd1;
					end
				end
				mflr_pkg::PH_YEAR: begin
					if (!dig) begin
						nxt = fail(nxt, mflr_pkg::RSN_YEAR);
					end else if (pos_e >= 3'd3) begin
						nxt = enter(nxt, mflr_pkg::PH_SP_MZ);
					end else begin
						nxt.pos = pos_e + 3'd1;
					end
				end
				mflr_pkg::PH_SP_MZ: begin
					if (c == mflr_pkg::CH_PLUS || c == mflr_pkg::CH_MINUS) begin
						nxt = enter(nxt, mflr_pkg::PH_MZ);
						nxt.pos = 3'd1;
					end else if (!sp) begin
						nxt = fail(nxt, mflr_pkg::RSN_EXTRA);
					end
				end
				mflr_pkg::PH_MZ: begin
					if (!dig) begin
						nxt = fail(nxt, mflr_pkg::RSN_EXTRA);
					end else if (pos_e >= 3'd4) begin
						nxt = enter(nxt, mflr_pkg::PH_TAIL);
					end else begin
						nxt.pos = pos_e + 3'd1;
					end
				end
				mflr_pkg::PH_TAIL: if (!sp) begin
					nxt = fail(nxt, mflr_pkg::RSN_EXTRA);
				end
				mflr_pkg::PH_SP_WDAY, mflr_pkg::PH_SP_MON, mflr_pkg::PH_SP_TIME,
				mflr_pkg::PH_SP_YEAR: begin
					// Only a space stays in these gaps, and a space changes nothing.
				end
				default: nxt = fail(nxt, mflr_pkg::RSN_EXTRA);
			endcase
		end
	end

endmodule

FILE: rtl/mbox_from_line_recognizer_core.sv
// Top level of the mailbox separator line recogniser: input stage, scan state, result register.
// A line end passes the input stage, then enters the result register once that has room.
// Throughput: one character or line end per cycle; the scan state updates once per transfer.
// The only hold-off is an end item meeting a full, stalled result register.
// Reset (arst_n low) empties both stages and returns the scanner to the start of a line.
`timescale 1ns / 1ps

module mbox_from_line_recognizer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       line_valid,
	output logic       line_stall,
	input  logic [7:0] line_byte,
	input  logic       line_end,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       is_message_start,
	output logic [2:0] reject_reason
);

	// Input stage: one registered transfer waiting to update the scan state.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Scan state of the line in progress.
	mflr_pkg::scan_state_t st_q;
	mflr_pkg::scan_state_t st_nxt;
	mflr_pkg::reason_t     code;

	// Result register, which decouples the scanner from the downstream stall.
	logic              res_valid_q;
	logic              res_match_q;
	mflr_pkg::reason_t res_reason_q;

	logic out_free;
	logic s1_go;

	// The result register can take a new verdict when it is empty or is being
	// emptied by a transfer in this cycle.
	assign out_free = !res_valid_q || !result_stall;

	// Ordinary characters never wait; a line end waits only for room in the
	// result register.
	assign s1_go = valid_s1 && (!end_s1 || out_free);
	assign line_stall = valid_s1 && end_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!line_stall) begin
			valid_s1 <= line_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_valid && !line_stall) begin
			byte_s1 <= line_byte;
			end_s1 <= line_end;
		end
	end

	mflr_step u_step (
		.st   (st_q),
		.c    (byte_s1),
		.eol  (end_s1),
		.nxt  (st_nxt),
		.code (code)
	);

	// The scan state advances once per character; a line end returns it to the
	// start-of-line values so that the next line follows without a gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mflr_pkg::SCAN_RESET;
		end else if (s1_go) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && end_s1) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && end_s1) begin
			res_match_q <= (code == mflr_pkg::RSN_OK);
			res_reason_q <= code;
		end
	end

	assign result_valid = res_valid_q;
	assign is_message_start = res_match_q;
	assign reject_reason = res_reason_q;

`ifndef ASSERT_OFF
	// A line end that is taken leaves the scanner at the start of a line.
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && end_s1 |=> st_q == mflr_pkg::SCAN_RESET)
		else $error("scan state not cleared after a line end");

	// A settled verdict holds until the line end is taken.
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.failed && !(s1_go && end_s1) |=> st_q.failed && $stable(st_q.fcode))
		else $error("failure verdict lost before the line end");

	// The input side is held off only by a line end facing a blocked result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		line_stall |-> valid_s1 && end_s1 && res_valid_q && result_stall)
		else $error("input stalled without a blocked result");

	// The match flag and the reason code always agree.
	a_match_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_match_q == (res_reason_q == mflr_pkg::RSN_OK))
		else $error("match flag disagrees with reason code");

	// A verdict is only loaded when a line end leaves the input stage.
	a_load_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q && !(s1_go && end_s1) |=> !res_valid_q)
		else $error("result appeared without a line end");
`endif

endmodule

FILE: bench/mflr_verdict_checker.sv
// Checker that predicts each line verdict of the separator line recogniser and compares results.
`timescale 1ns / 1ps

module mflr_verdict_checker
	import mflr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       line_valid,
	input  logic       line_stall,
	input  logic [7:0] line_byte,
	input  logic       line_end,
	input  logic       result_valid,
	input  logic       result_stall,
	input  logic       is_message_start,
	input  logic [2:0] reject_reason,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic    start;
		reason_t why;
	} verdict_t;

	verdict_t    verdict_q[$];

	phase_t      sc_phase;
	logic [2:0]  sc_pos;
	logic [11:0] sc_cand;
	reason_t     sc_code;
	logic        sc_failed;

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_cap(logic [7:0] c);
		return c >= "A" && c <= "Z";
	endfunction

	function automatic reason_t verdict_if_ended(phase_t ph);
		case (ph)
			PH_PREFIX: return RSN_PREFIX;
			PH_SP_ADDR, PH_ADDR, PH_SP_WDAY, PH_WDAY: return RSN_WEEKDAY;
			PH_SP_MON, PH_MON: return RSN_MONTH;
			PH_SP_DAY: return RSN_DAY;
			PH_DAYD, PH_SP_TIME, PH_TIME: return RSN_TIME;
			PH_SP_TZ, PH_TZ, PH_SP_YEAR, PH_YEAR: return RSN_YEAR;
			PH_SP_MZ, PH_TAIL: return RSN_OK;
			default: return RSN_EXTRA;
		endcase
	endfunction

	task automatic enter(phase_t ph);
		sc_phase = ph;
		sc_pos   = 3'd0;
		sc_cand  = '1;
	endtask

	task automatic give_up(reason_t r);
		sc_failed = 1'b1;
		sc_code   = r;
	endtask

	task automatic reset_scan();
		enter(PH_PREFIX);
		sc_code   = RSN_OK;
		sc_failed = 1'b0;
	endtask

	// Narrows the surviving weekday or month names by one character.
	function automatic logic match_name(logic [7:0] c, logic is_month);
		logic [11:0] hit;
		int          n;
		hit = '0;
		if (sc_pos > 3'd2)
			return 1'b0;
		n = is_month ? NUM_MONTHS : NUM_WDAYS;
		for (int i = 0; i < n; i++) begin
			if (is_month)
				hit[i] = (MONTH_TXT[i*3 + int'(sc_pos)] == c);
			else
				hit[i] = (WDAY_TXT[i*3 + int'(sc_pos)] == c);
		end
		sc_cand &= hit;
		if (sc_cand == '0)
			return 1'b0;
		sc_pos++;
		return 1'b1;
	endfunction

	// A gap that meets a non-space hands the same character on to the next field.
	task automatic scan_byte(logic [7:0] c);
		logic again;
		logic ok;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			case (sc_phase)
				PH_PREFIX: begin
					if (sc_pos > 3'd4 || c != PREFIX_TXT[sc_pos])
						give_up(RSN_PREFIX);
					else if (sc_pos == 3'd4)
						enter(PH_SP_ADDR);
					else
						sc_pos++;
				end
				PH_SP_ADDR: if (c != CH_SPACE) enter(PH_ADDR);
				PH_ADDR: if (c == CH_SPACE) enter(PH_SP_WDAY);
				PH_SP_WDAY: begin
					if (c != CH_SPACE) begin
						enter(PH_WDAY);
						again = 1'b1;
					end
				end
				PH_WDAY: begin
					if (!match_name(c, 1'b0))
						give_up(RSN_WEEKDAY);
					else if (sc_pos == 3'd3)
						enter(PH_SP_MON);
				end
				PH_SP_MON: begin
					if (c != CH_SPACE) begin
						enter(PH_MON);
						again = 1'b1;
					end
				end
				PH_MON: begin
					if (!match_name(c, 1'b1))
						give_up(RSN_MONTH);
					else if (sc_pos == 3'd3)
						enter(PH_SP_DAY);
				end
				PH_SP_DAY: begin
					if (c != CH_SPACE) begin
						if (!is_digit(c))
							give_up(RSN_DAY);
						else
							enter(PH_DAYD);
					end
				end
				PH_DAYD: begin
					if (c == CH_SPACE) begin
						enter(PH_SP_TIME);
					end else if (!is_digit(c)) begin
						enter(PH_TIME);
						again = 1'b1;
					end
				end
				PH_SP_TIME: begin
					if (c != CH_SPACE) begin
						enter(PH_TIME);
						again = 1'b1;
					end
				end
				PH_TIME: begin
					ok = (sc_pos == 3'd2 || sc_pos == 3'd5) ? (c == CH_COLON) : is_digit(c);
					if (!ok)
						give_up(RSN_TIME);
					else if (sc_pos >= 3'd7)
						enter(PH_SP_TZ);
					else
						sc_pos++;
				end
				PH_SP_TZ: begin
					if (c != CH_SPACE) begin
						if (is_cap(c)) begin
							enter(PH_TZ);
							sc_pos = 3'd1;
						end else begin
							enter(PH_YEAR);
							again = 1'b1;
						end
					end
				end
				PH_TZ: begin
					if (!is_cap(c))
						give_up(RSN_YEAR);
					else if (sc_pos >= 3'd2)
						enter(PH_SP_YEAR);
					else
						sc_pos++;
				end
				PH_SP_YEAR: begin
					if (c != CH_SPACE) begin
						enter(PH_YEAR);
						again = 1'b1;
					end
				end
				PH_YEAR: begin
					if (!is_digit(c))
						give_up(RSN_YEAR);
					else if (sc_pos >= 3'd3)
						enter(PH_SP_MZ);
					else
						sc_pos++;
				end
				PH_SP_MZ: begin
					if (c == CH_PLUS || c == CH_MINUS) begin
						enter(PH_MZ);
						sc_pos = 3'd1;
					end else if (c != CH_SPACE) begin
						give_up(RSN_EXTRA);
					end
				end
				PH_MZ: begin
					if (!is_digit(c))
						give_up(RSN_EXTRA);
					else if (sc_pos >= 3'd4)
						enter(PH_TAIL);
					else
						sc_pos++;
				end
				PH_TAIL: if (c != CH_SPACE) give_up(RSN_EXTRA);
				default: give_up(RSN_EXTRA);
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		reason_t  code;
		int       errs;
		if (!arst_n) begin
			reset_scan();
			verdict_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			errs = 0;
			// The result side is checked first: a verdict pushed at this edge cannot leave yet.
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: result transfer with no verdict waiting, actual start %0d reason %0d",
						$time, is_message_start, reject_reason);
					errs++;
				end else begin
					want = verdict_q.pop_front();
					if (is_message_start !== want.start) begin
						$display("%0t: is_message_start expected %0d actual %0d",
							$time, want.start, is_message_start);
						errs++;
					end
					if (reject_reason !== want.why) begin
						$display("%0t: reject_reason expected %0d actual %0d",
							$time, want.why, reject_reason);
						errs++;
					end
				end
			end
			if (line_valid && !line_stall) begin
				if (!line_end) begin
					if (!sc_failed) begin
						// A zero byte settles the verdict as if the line had ended.
						if (line_byte == CH_NUL)
							give_up(verdict_if_ended(sc_phase));
						else
							scan_byte(line_byte);
					end
				end else begin
					code       = sc_failed ? sc_code : verdict_if_ended(sc_phase);
					want.start = (code == RSN_OK);
					want.why   = code;
					verdict_q.push_back(want);
					reset_scan();
				end
			end
			fail_count <= fail_count + errs;
			pending    <= verdict_q.size();
		end
	end

endmodule

FILE: bench/mbox_from_line_recognizer_core_test.sv
// Top of the separator line recogniser bench: clock, reset, line stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module mbox_from_line_recognizer_core_test;
	import mflr_pkg::*;

	// The random part runs until both targets are met; at some forty characters a line, the item
	// target is the one that ends it.
	localparam int ITEM_TARGET = 1150;
	localparam int LINE_TARGET = 24;
	// Lines sent before the long result hold-off, and before the sender drains every verdict.
	localparam int HOLD_LINE   = 8;
	localparam int DRAIN_LINE  = 20;
	// Calm tail: the last stretch of transfers goes through with no idling on either side.
	localparam int CALM_ITEMS  = 150;
	// The longest correct stretch without a transfer is the long hold-off below; allow far more.
	localparam int IDLE_LIMIT  = 5000;
	localparam int LONG_HOLD   = 300;

	typedef enum int {
		DMG_FLIP,
		DMG_TRICKY,
		DMG_CUT,
		DMG_INSERT,
		DMG_APPEND
	} damage_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       line_valid   = 1'b0;
	logic [7:0] line_byte    = 8'h00;
	logic       line_end     = 1'b0;
	logic       result_stall = 1'b0;

	logic       line_stall;
	logic       result_valid;
	logic       is_message_start;
	logic [2:0] reject_reason;

	int         fail_count;
	int         pending;
	int         items_sent   = 0;
	int         lines_sent   = 0;
	int         idle_cycles  = 0;
	bit         calm         = 1'b0;
	bit         hold_done    = 1'b0;

	// The characters of the line being built, sent in order and then closed by an end transfer.
	logic [7:0] text[$];

	mbox_from_line_recognizer_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.line_valid       (line_valid),
		.line_stall       (line_stall),
		.line_byte        (line_byte),
		.line_end         (line_end),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.is_message_start (is_message_start),
		.reject_reason    (reject_reason)
	);

	mflr_verdict_checker u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.line_valid       (line_valid),
		.line_stall       (line_stall),
		.line_byte        (line_byte),
		.line_end         (line_end),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.is_message_start (is_message_start),
		.reject_reason    (reject_reason),
		.fail_count       (fail_count),
		.pending          (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// The watchdog restarts its count on every transfer; a hung block ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (line_valid && !line_stall) || (result_valid && !result_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL mbox_from_line_recognizer_core");
				$finish;
			end
		end
	end

	// The result side stalls in random bursts. Once enough lines have gone, it holds off for a
	// long stretch so that the result register fills and the block has to stall the line side.
	initial begin
		forever begin
			if (!hold_done && lines_sent >= HOLD_LINE) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endtask

	task automatic add_spaces(int lo, int hi);
		repeat ($urandom_range(lo, hi)) text.push_back(CH_SPACE);
	endtask

	task automatic add_digits(int n);
		repeat (n) text.push_back(8'(8'h30 + $urandom_range(0, 9)));
	endtask

	task automatic add_caps(int n);
		repeat (n) text.push_back(8'(8'h41 + $urandom_range(0, 25)));
	endtask

	// Address characters are mostly printable, now and then any byte but a space or a zero.
	function automatic logic [7:0] addr_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 3) == 0)
				c = 8'($urandom_range(1, 255));
			else
				c = 8'($urandom_range(33, 126));
		end while (c == CH_SPACE);
		return c;
	endfunction

	// Characters that sit close to what the pattern wants, so that damage lands on near misses.
	function automatic logic [7:0] tricky_char();
		case ($urandom_range(0, 7))
			0: return CH_SPACE;
			1: return CH_COLON;
			2: return CH_PLUS;
			3: return CH_MINUS;
			4: return 8'(8'h30 + $urandom_range(0, 9));
			5: return 8'(8'h41 + $urandom_range(0, 25));
			6: return 8'(8'h61 + $urandom_range(0, 25));
			default: return CH_NUL;
		endcase
	endfunction

	// A separator line with random content in every field; it follows the pattern unless the day gap below is empty.
	task automatic build_good_line();
		int k;
		text.delete();
		add_str("From ");
		add_spaces(0, 1);
		repeat ($urandom_range(1, 8)) text.push_back(addr_char());
		add_spaces(1, 3);
		k = $urandom_range(0, NUM_WDAYS - 1);
		for (int i = 0; i < 3; i++)
			text.push_back(WDAY_TXT[k*3 + i]);
		add_spaces(0, 2);
		k = $urandom_range(0, NUM_MONTHS - 1);
		for (int i = 0; i < 3; i++)
			text.push_back(MONTH_TXT[k*3 + i]);
		add_spaces(0, 2);
		add_digits($urandom_range(1, 3));
		// With no space the time digits run on into the day number, which the block must reject.
		add_spaces(($urandom_range(0, 7) == 0) ? 0 : 1, 2);
		add_digits(2);
		text.push_back(CH_COLON);
		add_digits(2);
		text.push_back(CH_COLON);
		add_digits(2);
		add_spaces(0, 2);
		if ($urandom_range(0, 4) < 2) begin
			add_caps(3);
			add_spaces(0, 2);
		end
		add_digits(4);
		if ($urandom_range(0, 1) == 1) begin
			add_spaces(0, 2);
			text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
			add_digits(4);
		end
		add_spaces(0, 2);
	endtask

	task automatic damage_line();
		int at;
		at = $urandom_range(0, text.size() - 1);
		case (damage_t'($urandom_range(0, 4)))
			DMG_FLIP:   text[at] = 8'($urandom_range(0, 255));
			DMG_TRICKY: text[at] = tricky_char();
			DMG_CUT:    while (text.size() > at) void'(text.pop_back());
			DMG_INSERT: text.insert(at, tricky_char());
			default:    repeat ($urandom_range(1, 3)) text.push_back(tricky_char());
		endcase
	endtask

	// Now and then the sender leaves a gap before its next transfer.
	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 11) == 0) begin
			line_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Offers one transfer and holds it steady until the block takes it.
	task automatic send_item(logic [7:0] b, logic e);
		line_valid <= 1'b1;
		line_byte  <= b;
		line_end   <= e;
		@(posedge clk);
		while (line_stall) @(posedge clk);
		items_sent++;
	endtask

	// The byte that rides along with an end transfer is random, since the block ignores it.
	task automatic send_line();
		foreach (text[i]) begin
			maybe_gap();
			send_item(text[i], 1'b0);
		end
		maybe_gap();
		send_item(8'($urandom_range(0, 255)), 1'b1);
		lines_sent++;
	endtask

	// The wait before polling lets the checker's count catch up with an end transfer taken just now.
	task automatic wait_for_verdicts();
		line_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short directed lines: an empty line, the top byte value, a zero byte inside the prefix
		// with bytes after it, an end inside the prefix, an end inside the address, and a zero
		// byte that follows a settled failure.
		text.delete();
		send_line();
		text = '{8'hFF};
		send_line();
		text.delete();
		add_str("Fr");
		text.push_back(CH_NUL);
		add_str("Q");
		send_line();
		text.delete();
		add_str("From");
		send_line();
		text.delete();
		add_str("From x");
		send_line();
		text.delete();
		add_str("X");
		text.push_back(CH_NUL);
		send_line();

		// Random part: mostly well-formed lines, some damaged, and some pure noise.
		while (items_sent < ITEM_TARGET || lines_sent < LINE_TARGET) begin
			calm = (items_sent > ITEM_TARGET - CALM_ITEMS);
			if (lines_sent == DRAIN_LINE)
				wait_for_verdicts();
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				build_good_line();
			end else if (pick < 85) begin
				build_good_line();
				damage_line();
				if ($urandom_range(0, 3) == 0)
					damage_line();
			end else begin
				text.delete();
				repeat ($urandom_range(0, 10)) text.push_back(8'($urandom_range(0, 255)));
			end
			send_line();
		end

		wait_for_verdicts();
		repeat (5) @(posedge clk);
		if (fail_count == 0)
			$display("PASS mbox_from_line_recognizer_core");
		else
			$display("FAIL mbox_from_line_recognizer_core");
		$finish;
	end

endmodule
